// ----- design/loconet_link_transceiver_unit_macros.svh -----
// Assertion macros for the LocoNet link transceiver.
`ifndef LOCONET_LINK_TRANSCEIVER_UNIT_MACROS_SVH
`define LOCONET_LINK_TRANSCEIVER_UNIT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define LLT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain condition checked on every rising edge outside reset.
`define LLT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- design/llt_pkg.sv -----
// Shared types and constants for the LocoNet link transceiver.
package llt_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QF_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [7:0] STOP_TICK = 8'd9;
    localparam logic [7:0] TICK_MAX  = 8'hFF;

    localparam logic [7:0] BREAK_RESET   = 8'd15;
    localparam logic [7:0] CARRIER_RESET = 8'd20;
    localparam logic [7:0] BACKOFF_RESET = 8'd40;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_PUSH  = 2'd2,
        KIND_SEND  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_RX      = 3'd1,
        MODE_TX      = 3'd2,
        MODE_COLL    = 3'd3,
        MODE_BACKOFF = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        SEND_STARTED  = 3'd0,
        SEND_CARRIER  = 3'd1,
        SEND_PRIORITY = 3'd2,
        SEND_BUSY     = 3'd3,
        SEND_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_BREAK   = 2'd0,
        REG_CARRIER = 2'd1,
        REG_BACKOFF = 2'd2
    } reg_idx_t;

    typedef struct packed {
        kind_t      kind;
        logic       line_level;
        logic [7:0] tx_byte;
        logic [7:0] prio_delay;
    } item_t;

    typedef struct packed {
        logic       line_drive;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       framing_error;
        logic       collision;
        logic       tx_done;
        status_t    send_status;
        mode_t      link_state;
    } result_t;

    typedef struct packed {
        logic [7:0] break_ticks;
        logic [7:0] carrier_ticks;
        logic [7:0] backoff_limit;
    } cfg_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       flush;
        logic [7:0] data;
    } q_ctrl_t;

    typedef struct packed {
        logic [QF_W-1:0] fill;
        logic [7:0]      head_byte;
    } q_stat_t;

endpackage

// ----- design/llt_cfg.sv -----
// APB register block holding the link timing settings.
module llt_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [llt_pkg::PADDR_W-1:0]  paddr,
    input  logic [llt_pkg::PDATA_W-1:0]  pwdata,
    output logic [llt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output llt_pkg::cfg_t                cfg
);

    llt_pkg::cfg_t    cfg_reg;
    llt_pkg::cfg_t    cfg_next;
    llt_pkg::reg_idx_t idx;
    logic             wr_en;
    logic [7:0]       rd_val;

    assign pready = 1'b1;
    assign idx    = llt_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                llt_pkg::REG_BREAK:   cfg_next.break_ticks   = pwdata[7:0];
                llt_pkg::REG_CARRIER: cfg_next.carrier_ticks = pwdata[7:0];
                llt_pkg::REG_BACKOFF: cfg_next.backoff_limit = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            llt_pkg::REG_BREAK:   rd_val = cfg_reg.break_ticks;
            llt_pkg::REG_CARRIER: rd_val = cfg_reg.carrier_ticks;
            llt_pkg::REG_BACKOFF: rd_val = cfg_reg.backoff_limit;
            default:              rd_val = 8'd0;
        endcase
    end

    assign prdata = {{(llt_pkg::PDATA_W-8){1'b0}}, rd_val};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.break_ticks   <= llt_pkg::BREAK_RESET;
            cfg_reg.carrier_ticks <= llt_pkg::CARRIER_RESET;
            cfg_reg.backoff_limit <= llt_pkg::BACKOFF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/llt_queue.sv -----
// Circular transmit byte queue with registered head read and write bypass.
module llt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  llt_pkg::q_ctrl_t ctrl,
    output llt_pkg::q_stat_t stat
);

    localparam int SUM_W = llt_pkg::QF_W + 1;

    logic [7:0]              mem [llt_pkg::QUEUE_DEPTH];
    logic [llt_pkg::QA_W-1:0] head_reg, head_next, head_inc;
    logic [llt_pkg::QF_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]         wr_sum, wr_wrap;
    logic [llt_pkg::QA_W-1:0] wr_addr;
    logic                     wr_en;
    logic [7:0]               rd_q_reg;
    logic                     byp_reg;
    logic [7:0]               byp_data_reg;

    assign head_inc = (head_reg == llt_pkg::QA_W'(llt_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : head_reg + 1'b1;

    assign wr_sum  = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign wr_wrap = (wr_sum >= SUM_W'(llt_pkg::QUEUE_DEPTH)) ?
                     wr_sum - SUM_W'(llt_pkg::QUEUE_DEPTH) : wr_sum;
    assign wr_addr = wr_wrap[llt_pkg::QA_W-1:0];
    assign wr_en   = ctrl.push && (fill_reg < llt_pkg::QF_W'(llt_pkg::QUEUE_DEPTH));

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ctrl.flush)
        begin
            fill_next = '0;
        end
        else if (ctrl.pop)
        begin
            head_next = head_inc;
            fill_next = fill_reg - 1'b1;
        end
        else if (wr_en)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= ctrl.data;
        end
    end

    // head is read every cycle; a write to the entry being read is forwarded
    always_ff @(posedge clk)
    begin
        rd_q_reg     <= mem[head_next];
        byp_data_reg <= ctrl.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= wr_en && (wr_addr == head_next);
        end
    end

    assign stat.fill      = fill_reg;
    assign stat.head_byte = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

// ----- design/llt_core.sv -----
// Link state machine: receive, transmit, collision break and backoff.
module llt_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  llt_pkg::item_t   item,
    input  llt_pkg::cfg_t    cfg,
    input  llt_pkg::q_stat_t q_stat,
    output llt_pkg::q_ctrl_t q_ctrl,
    output llt_pkg::result_t res
);

    llt_pkg::mode_t   mode_reg, mode_next;
    logic [7:0]       tick_reg, tick_next;
    logic [7:0]       rx_shift_reg, rx_shift_next;
    logic [7:0]       tx_shift_reg, tx_shift_next;
    logic             drive_reg, drive_next;
    logic             sdet_reg, sdet_next;
    logic             ev_rxv, ev_ferr, ev_coll, ev_done;
    llt_pkg::status_t ev_status;

    always_comb
    begin
        llt_pkg::mode_t mode_s;
        mode_s        = mode_reg;
        mode_next     = mode_reg;
        tick_next     = tick_reg;
        rx_shift_next = rx_shift_reg;
        tx_shift_next = tx_shift_reg;
        drive_next    = drive_reg;
        sdet_next     = sdet_reg;
        ev_rxv        = 1'b0;
        ev_ferr       = 1'b0;
        ev_coll       = 1'b0;
        ev_done       = 1'b0;
        ev_status     = llt_pkg::SEND_STARTED;
        q_ctrl        = '0;
        q_ctrl.data   = item.tx_byte;
        if (go)
        begin
            case (item.kind)
                llt_pkg::KIND_TICK:
                begin
                    if (mode_reg != llt_pkg::MODE_IDLE)
                    begin
                        if (tick_reg != llt_pkg::TICK_MAX)
                        begin
                            tick_next = tick_reg + 8'd1;
                        end
                        case (mode_reg)
                            llt_pkg::MODE_RX:
                            begin
                                if (tick_next < llt_pkg::STOP_TICK)
                                begin
                                    rx_shift_next = {item.line_level, rx_shift_reg[7:1]};
                                end
                                else
                                begin
                                    ev_ferr   = !item.line_level;
                                    ev_rxv    = item.line_level;
                                    tick_next = 8'd0;
                                    mode_next = llt_pkg::MODE_BACKOFF;
                                end
                            end
                            llt_pkg::MODE_TX:
                            begin
                                if (item.line_level != drive_reg)
                                begin
                                    tick_next    = 8'd0;
                                    mode_next    = llt_pkg::MODE_COLL;
                                    q_ctrl.flush = 1'b1;
                                end
                                else if (tick_next < llt_pkg::STOP_TICK)
                                begin
                                    drive_next    = tx_shift_reg[0];
                                    tx_shift_next = {1'b0, tx_shift_reg[7:1]};
                                end
                                else if (tick_next == llt_pkg::STOP_TICK)
                                begin
                                    drive_next = 1'b1;
                                end
                                else if (q_stat.fill != '0)
                                begin
                                    tx_shift_next = q_stat.head_byte;
                                    q_ctrl.pop    = 1'b1;
                                    tick_next     = 8'd0;
                                    drive_next    = 1'b0;
                                end
                                else
                                begin
                                    ev_done   = 1'b1;
                                    tick_next = 8'd0;
                                    mode_next = llt_pkg::MODE_BACKOFF;
                                end
                            end
                            default: ;
                        endcase
                        if (mode_next == llt_pkg::MODE_COLL)
                        begin
                            if (tick_next == 8'd0)
                            begin
                                drive_next = 1'b0;
                            end
                            else if (tick_next >= cfg.break_ticks)
                            begin
                                drive_next = 1'b1;
                                tick_next  = 8'd0;
                                mode_next  = llt_pkg::MODE_BACKOFF;
                                ev_coll    = 1'b1;
                            end
                        end
                        if (mode_next == llt_pkg::MODE_BACKOFF)
                        begin
                            if (tick_next == 8'd0)
                            begin
                                sdet_next = 1'b1;
                            end
                            else if (tick_next >= cfg.backoff_limit)
                            begin
                                mode_next = llt_pkg::MODE_IDLE;
                            end
                        end
                    end
                end
                llt_pkg::KIND_START:
                begin
                    if (sdet_reg && (mode_reg == llt_pkg::MODE_IDLE ||
                                     mode_reg == llt_pkg::MODE_BACKOFF))
                    begin
                        sdet_next     = 1'b0;
                        mode_next     = llt_pkg::MODE_RX;
                        tick_next     = 8'd0;
                        rx_shift_next = 8'd0;
                    end
                end
                llt_pkg::KIND_PUSH:
                begin
                    q_ctrl.push = 1'b1;
                end
                llt_pkg::KIND_SEND:
                begin
                    if (q_stat.fill == '0)
                    begin
                        ev_status = llt_pkg::SEND_EMPTY;
                    end
                    else
                    begin
                        if (mode_reg == llt_pkg::MODE_BACKOFF && tick_reg >= item.prio_delay)
                        begin
                            mode_s = llt_pkg::MODE_IDLE;
                        end
                        if (mode_s == llt_pkg::MODE_BACKOFF)
                        begin
                            ev_status = (tick_reg < cfg.carrier_ticks) ?
                                        llt_pkg::SEND_CARRIER : llt_pkg::SEND_PRIORITY;
                        end
                        else if (mode_s != llt_pkg::MODE_IDLE)
                        begin
                            ev_status = llt_pkg::SEND_BUSY;
                        end
                        else
                        begin
                            tx_shift_next = q_stat.head_byte;
                            q_ctrl.pop    = 1'b1;
                            sdet_next     = 1'b0;
                            drive_next    = 1'b0;
                            tick_next     = 8'd0;
                            mode_next     = llt_pkg::MODE_TX;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.line_drive    = drive_next;
        res.rx_byte       = ev_rxv ? rx_shift_reg : 8'd0;
        res.rx_valid      = ev_rxv;
        res.framing_error = ev_ferr;
        res.collision     = ev_coll;
        res.tx_done       = ev_done;
        res.send_status   = ev_status;
        res.link_state    = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= llt_pkg::MODE_IDLE;
            tick_reg     <= 8'd0;
            rx_shift_reg <= 8'd0;
            tx_shift_reg <= 8'd0;
            drive_reg    <= 1'b1;
            sdet_reg     <= 1'b1;
        end
        else
        begin
            mode_reg     <= mode_next;
            tick_reg     <= tick_next;
            rx_shift_reg <= rx_shift_next;
            tx_shift_reg <= tx_shift_next;
            drive_reg    <= drive_next;
            sdet_reg     <= sdet_next;
        end
    end

endmodule

// ----- design/loconet_link_transceiver_unit.sv -----
// Top level of the LocoNet link transceiver: input and result registers around the core.
// Each item passes the input register and then the result register, which can stall, before its result is valid.
// Throughput: one item per cycle while results are taken; the state update and queue head read close in the same cycle.
// The queue head is read from a registered memory port every cycle, with write forwarding.
// Reset: asynchronous, active low; link idle, line released, queue empty, registers to defaults.
// Queue contents are not cleared; only written entries are ever read, so no clearing pass.
`include "loconet_link_transceiver_unit_macros.svh"

module loconet_link_transceiver_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  llt_pkg::item_t               item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output llt_pkg::result_t             result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [llt_pkg::PADDR_W-1:0]  paddr,
    input  logic [llt_pkg::PDATA_W-1:0]  pwdata,
    output logic [llt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    llt_pkg::item_t   item_reg;
    logic             item_vld_reg, item_vld_next;
    llt_pkg::result_t result_reg;
    logic             result_vld_reg, result_vld_next;
    llt_pkg::result_t core_res;
    llt_pkg::cfg_t    cfg;
    llt_pkg::q_ctrl_t q_ctrl;
    llt_pkg::q_stat_t q_stat;
    logic             advance;

    assign advance    = item_vld_reg && (!result_vld_reg || result_ready);
    assign item_ready = !item_vld_reg || advance;

    assign item_vld_next   = (item_valid && item_ready) ? 1'b1 :
                             (advance ? 1'b0 : item_vld_reg);
    assign result_vld_next = advance ? 1'b1 : (result_ready ? 1'b0 : result_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            result_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg   <= item_vld_next;
            result_vld_reg <= result_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= core_res;
        end
    end

    llt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    llt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat)
    );

    llt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .q_stat (q_stat),
        .q_ctrl (q_ctrl),
        .res    (core_res)
    );

    assign result_valid = result_vld_reg;
    assign result       = result_reg;

    `LLT_ASSERT_IMP(a_ready_when_free, !result_valid, item_ready, "input stalled with result register free")
    `LLT_ASSERT_ALWAYS(a_fill_bound, q_stat.fill <= llt_pkg::QF_W'(llt_pkg::QUEUE_DEPTH), "queue fill beyond depth")
    `LLT_ASSERT_IMP(a_rx_to_backoff, result_valid && result.rx_valid, !result.framing_error && result.link_state == llt_pkg::MODE_BACKOFF, "received byte without entering backoff")
    `LLT_ASSERT_IMP(a_coll_release, result_valid && result.collision, result.line_drive && result.link_state == llt_pkg::MODE_BACKOFF, "collision break end without line release")

endmodule
